[hdl/rsi_pkg.sv]
// Shared constants and types for the ray and sphere intersection unit.
package rsi_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int MUL_DIGIT   = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_RADIUS   = 3'd3,
      CSR_ACTIVE   = 3'd4
   } csr_index_type;

endpackage

[hdl/rsi_mul.sv]
// Pipelined signed multiplier that adds one digit-wide partial product per stage.
module rsi_mul
   import rsi_pkg::*;
#(
   parameter int AW  = 33,
   parameter int BW  = 33,
   parameter int DIG = MUL_DIGIT
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [AW-1:0]     a,
   input  logic signed [BW-1:0]     b,
   output logic signed [AW+BW-1:0]  p
);

   localparam int NS = (BW + DIG - 1) / DIG;
   localparam int BP = NS * DIG;
   localparam int PW = AW + BP;

   logic signed [PW-1:0] acc_ff [NS];
   logic signed [AW-1:0] a_ff   [NS];
   logic signed [BP-1:0] b_ff   [NS];

   genvar k;
   for (k = 0; k < NS; k++) begin : g_stage
      logic signed [PW-1:0]    acc_prev;
      logic signed [AW-1:0]    a_prev;
      logic signed [BP-1:0]    b_prev;
      logic signed [DIG:0]     digit;
      logic signed [AW+DIG:0]  term;
      logic signed [PW-1:0]    acc_in;

      if (k == 0) begin : g_first
         assign acc_prev = '0;
         assign a_prev   = a;
         assign b_prev   = BP'(b);
      end else begin : g_next
         assign acc_prev = acc_ff[k-1];
         assign a_prev   = a_ff[k-1];
         assign b_prev   = b_ff[k-1];
      end

      if (k == NS - 1) begin : g_top_digit
         assign digit = {b_prev[k*DIG+DIG-1], b_prev[k*DIG +: DIG]};
      end else begin : g_low_digit
         assign digit = {1'b0, b_prev[k*DIG +: DIG]};
      end

      assign term   = a_prev * digit;
      assign acc_in = acc_prev + (PW'(term) <<< (k * DIG));

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_in;
            a_ff[k]   <= a_prev;
            b_ff[k]   <= b_prev;
         end
      end
   end

   assign p = acc_ff[NS-1][AW+BW-1:0];

endmodule

[hdl/rsi_sqrt.sv]
// Pipelined integer square root that settles one root bit per stage.
module rsi_sqrt #(
   parameter int XW = 136,
   parameter int TW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [XW-1:0]     x,
   input  logic [TW-1:0]     in_tag,
   output logic              out_valid,
   output logic [XW/2-1:0]   root,
   output logic [TW-1:0]     out_tag
);

   localparam int RW = XW / 2;

   logic [XW-1:0] rem_ff   [RW];
   logic [RW-1:0] root_ff  [RW];
   logic [TW-1:0] tag_ff   [RW];
   logic [RW-1:0] valid_ff;

   genvar k;
   for (k = 0; k < RW; k++) begin : g_stage
      localparam int B = RW - 1 - k;
      logic [XW-1:0] rem_prev;
      logic [RW-1:0] root_prev;
      logic [TW-1:0] tag_prev;
      logic          valid_prev;
      logic [XW-1:0] trial;
      logic          ge;
      logic [XW-1:0] rem_in;
      logic [RW-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev   = x;
         assign root_prev  = '0;
         assign tag_prev   = in_tag;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign trial  = (XW'(root_prev) << (B + 1)) | (XW'(1) << (2 * B));
      assign ge     = (rem_prev >= trial);
      assign rem_in = ge ? (rem_prev - trial) : rem_prev;

      always_comb begin
         root_in    = root_prev;
         root_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            tag_ff[k]  <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

[hdl/rsi_div.sv]
// Pipelined restoring divider that settles one quotient bit per stage.
module rsi_div #(
   parameter int DW = 68,
   parameter int QB = 31,
   parameter int TW = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [DW+QB-1:0]    n,
   input  logic [DW-1:0]       d,
   input  logic [TW-1:0]       in_tag,
   output logic                out_valid,
   output logic [QB-1:0]       q,
   output logic [TW-1:0]       out_tag
);

   localparam int EW = DW + QB;

   logic [EW-1:0] rem_ff [QB];
   logic [DW-1:0] d_ff   [QB];
   logic [QB-1:0] q_ff   [QB];
   logic [TW-1:0] tag_ff [QB];
   logic [QB-1:0] valid_ff;

   genvar k;
   for (k = 0; k < QB; k++) begin : g_stage
      localparam int B = QB - 1 - k;
      logic [EW-1:0] rem_prev;
      logic [DW-1:0] d_prev;
      logic [QB-1:0] q_prev;
      logic [TW-1:0] tag_prev;
      logic          valid_prev;
      logic [EW-1:0] trial;
      logic          ge;
      logic [EW-1:0] rem_in;
      logic [QB-1:0] q_in;

      if (k == 0) begin : g_first
         assign rem_prev   = n;
         assign d_prev     = d;
         assign q_prev     = '0;
         assign tag_prev   = in_tag;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign d_prev     = d_ff[k-1];
         assign q_prev     = q_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign trial  = EW'(d_prev) << B;
      assign ge     = (rem_prev >= trial);
      assign rem_in = ge ? (rem_prev - trial) : rem_prev;

      always_comb begin
         q_in    = q_prev;
         q_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
         if (en) begin
            rem_ff[k] <= rem_in;
            d_ff[k]   <= d_prev;
            q_ff[k]   <= q_in;
            tag_ff[k] <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign q         = q_ff[QB-1];
   assign out_tag   = tag_ff[QB-1];

endmodule

[hdl/rsi_front.sv]
// Front end: takes rays, forms the origin offset, flags live rays and queues them.
module rsi_front
   import rsi_pkg::*;
#(
   parameter int CW = COORD_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [CW-1:0]        req_origin_x,
   input  logic signed [CW-1:0]        req_origin_y,
   input  logic signed [CW-1:0]        req_origin_z,
   input  logic signed [CW-1:0]        req_dir_x,
   input  logic signed [CW-1:0]        req_dir_y,
   input  logic signed [CW-1:0]        req_dir_z,
   input  logic signed [CW-1:0]        center_x,
   input  logic signed [CW-1:0]        center_y,
   input  logic signed [CW-1:0]        center_z,
   input  logic                        target_active,
   output logic                        head_valid,
   output logic [6*CW+3:0]             head_item,
   input  logic                        head_pop
);

   localparam int OW = CW + 1;
   localparam int IW = 3 * OW + 3 * CW + 1;

   logic                   f_valid_ff, f_valid_in;
   logic [IW-1:0]          f_item_ff, f_item_in;
   logic [IW-1:0]          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   full, push, take, live;
   logic signed [OW-1:0]   oc_x, oc_y, oc_z;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = f_valid_ff && !full;
   assign req_stall = f_valid_ff && full;
   assign take      = req_valid && !req_stall;

   assign oc_x = OW'(req_origin_x) - OW'(center_x);
   assign oc_y = OW'(req_origin_y) - OW'(center_y);
   assign oc_z = OW'(req_origin_z) - OW'(center_z);
   assign live = target_active && ((req_dir_x != '0) || (req_dir_y != '0) || (req_dir_z != '0));

   assign f_valid_in = take || (f_valid_ff && !push);
   assign f_item_in  = take ? {live, req_dir_z, req_dir_y, req_dir_x, oc_z, oc_y, oc_x}
                            : f_item_ff;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = head_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(head_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         f_valid_ff <= f_valid_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
      f_item_ff <= f_item_in;
      if (push) begin
         mem_ff[wr_ptr_ff] <= f_item_ff;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("Queue count exceeds its depth.");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> (count_ff != '0))
      else $error("Back end popped an empty queue.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !head_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("Queue count did not follow a lone push.");

endmodule

[hdl/rsi_back.sv]
// Back end: products, discriminant, square root, root choice and division.
module rsi_back
   import rsi_pkg::*;
#(
   parameter int CW = COORD_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  logic [6*CW+3:0]     head_item,
   output logic                head_pop,
   input  logic [CW-2:0]       sphere_radius,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [CW-2:0]       rsp_hit_distance
);

   localparam int OW  = CW + 1;
   localparam int IW  = 3 * OW + 3 * CW + 1;
   localparam int PW1 = 2 * OW;
   localparam int HW  = 2 * CW + 4;
   localparam int QW  = 2 * HW;
   localparam int NW  = HW + 2;
   localparam int SW  = NW - 1 + FB;
   localparam int QB  = CW - 1;
   localparam int EW  = HW + QB;
   localparam int MW  = SW + EW;
   localparam int L1  = (OW + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int L3  = (HW + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int TW5 = 1 + 2 * HW;

   logic en;

   logic signed [OW-1:0]  oc_v [3];
   logic signed [CW-1:0]  d_raw [3];
   logic signed [OW-1:0]  d_v [3];
   logic signed [OW-1:0]  r_v;
   logic                  live0;
   logic signed [PW1-1:0] dd [3];
   logic signed [PW1-1:0] od [3];
   logic signed [PW1-1:0] oo [3];
   logic signed [PW1-1:0] rr;

   logic [L1-1:0] v1_ff, live1_ff;

   logic signed [HW-1:0] a2_ff, a2_in, h2_ff, h2_in, c2_ff, c2_in;
   logic                 v2_ff, live2_ff;

   logic signed [QW-1:0] hh, ac;
   logic [L3-1:0]        v3_ff, live3_ff;
   logic signed [HW-1:0] h3_ff [L3];
   logic signed [HW-1:0] a3_ff [L3];

   logic signed [QW-1:0] q4_ff, q4_in;
   logic signed [HW-1:0] h4_ff, a4_ff;
   logic                 v4_ff, live4_ff, live4_in;

   logic                 sq_valid;
   logic [HW-1:0]        sq_root;
   logic [TW5-1:0]       sq_tag;
   logic                 live5;
   logic signed [HW-1:0] h5;
   logic [HW-1:0]        a5;

   logic signed [NW-1:0] h_e, s_e, n1, n2;
   logic [SW-1:0]        sh1, sh2;
   logic                 ok1, ok2;
   logic                 v6_ff, hit6_ff, hit6_in;
   logic [SW-1:0]        nsh6_ff, nsh6_in;
   logic [HW-1:0]        a6_ff;

   logic                 v7_ff, hit7_ff, sat7_ff, sat7_in;
   logic [EW-1:0]        num7_ff, num7_in;
   logic [HW-1:0]        a7_ff;

   logic                 dv_valid;
   logic [QB-1:0]        dv_q;
   logic [1:0]           dv_tag;

   logic                 rsp_valid_ff, rsp_hit_ff;
   logic [CW-2:0]        rsp_hit_distance_ff, rsp_hit_distance_in;

   assign en       = !rsp_valid_ff || !rsp_stall;
   assign head_pop = en && head_valid;

   genvar j;
   for (j = 0; j < 3; j++) begin : g_axis
      assign oc_v[j]  = head_item[j*OW +: OW];
      assign d_raw[j] = head_item[3*OW + j*CW +: CW];
      assign d_v[j]   = OW'(d_raw[j]);

      rsi_mul #(.AW(OW), .BW(OW)) u_dd (
         .clock(clock), .en(en), .a(d_v[j]), .b(d_v[j]), .p(dd[j]));
      rsi_mul #(.AW(OW), .BW(OW)) u_od (
         .clock(clock), .en(en), .a(oc_v[j]), .b(d_v[j]), .p(od[j]));
      rsi_mul #(.AW(OW), .BW(OW)) u_oo (
         .clock(clock), .en(en), .a(oc_v[j]), .b(oc_v[j]), .p(oo[j]));
   end

   assign live0 = head_item[IW-1];
   assign r_v   = signed'({2'b00, sphere_radius});

   rsi_mul #(.AW(OW), .BW(OW)) u_rr (
      .clock(clock), .en(en), .a(r_v), .b(r_v), .p(rr));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
      end else if (en) begin
         v1_ff[0] <= head_valid;
         for (int i = 1; i < L1; i++) begin
            v1_ff[i] <= v1_ff[i-1];
         end
      end
      if (en) begin
         live1_ff[0] <= live0;
         for (int i = 1; i < L1; i++) begin
            live1_ff[i] <= live1_ff[i-1];
         end
      end
   end

   assign a2_in = HW'(dd[0]) + HW'(dd[1]) + HW'(dd[2]);
   assign h2_in = HW'(od[0]) + HW'(od[1]) + HW'(od[2]);
   assign c2_in = HW'(oo[0]) + HW'(oo[1]) + HW'(oo[2]) - HW'(rr);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff[L1-1];
      end
      if (en) begin
         live2_ff <= live1_ff[L1-1];
         a2_ff    <= a2_in;
         h2_ff    <= h2_in;
         c2_ff    <= c2_in;
      end
   end

   rsi_mul #(.AW(HW), .BW(HW)) u_hh (
      .clock(clock), .en(en), .a(h2_ff), .b(h2_ff), .p(hh));
   rsi_mul #(.AW(HW), .BW(HW)) u_ac (
      .clock(clock), .en(en), .a(a2_ff), .b(c2_ff), .p(ac));

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= '0;
      end else if (en) begin
         v3_ff[0] <= v2_ff;
         for (int i = 1; i < L3; i++) begin
            v3_ff[i] <= v3_ff[i-1];
         end
      end
      if (en) begin
         live3_ff[0] <= live2_ff;
         h3_ff[0]    <= h2_ff;
         a3_ff[0]    <= a2_ff;
         for (int i = 1; i < L3; i++) begin
            live3_ff[i] <= live3_ff[i-1];
            h3_ff[i]    <= h3_ff[i-1];
            a3_ff[i]    <= a3_ff[i-1];
         end
      end
   end

   assign q4_in    = hh - ac;
   assign live4_in = live3_ff[L3-1] && !q4_in[QW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff[L3-1];
      end
      if (en) begin
         live4_ff <= live4_in;
         q4_ff    <= q4_in;
         h4_ff    <= h3_ff[L3-1];
         a4_ff    <= a3_ff[L3-1];
      end
   end

   rsi_sqrt #(.XW(QW), .TW(TW5)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v4_ff),
      .x        (q4_ff),
      .in_tag   ({live4_ff, h4_ff, a4_ff}),
      .out_valid(sq_valid),
      .root     (sq_root),
      .out_tag  (sq_tag)
   );

   assign live5 = sq_tag[TW5-1];
   assign h5    = sq_tag[2*HW-1:HW];
   assign a5    = sq_tag[HW-1:0];

   assign h_e = NW'(h5);
   assign s_e = signed'(NW'(sq_root));
   assign n1  = -h_e - s_e;
   assign n2  = -h_e + s_e;
   assign sh1 = SW'(n1[NW-2:0]) << FB;
   assign sh2 = SW'(n2[NW-2:0]) << FB;
   assign ok1 = !n1[NW-1] && (sh1 >= SW'(a5));
   assign ok2 = !n2[NW-1] && (sh2 >= SW'(a5));

   assign hit6_in = live5 && (ok1 || ok2);
   assign nsh6_in = ok1 ? sh1 : sh2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= sq_valid;
      end
      if (en) begin
         hit6_ff <= hit6_in;
         nsh6_ff <= nsh6_in;
         a6_ff   <= a5;
      end
   end

   assign sat7_in = (MW'(nsh6_ff) >= (MW'(a6_ff) << QB));
   assign num7_in = (sat7_in || !hit6_ff) ? '0 : EW'(nsh6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
      if (en) begin
         hit7_ff <= hit6_ff;
         sat7_ff <= sat7_in;
         num7_ff <= num7_in;
         a7_ff   <= a6_ff;
      end
   end

   rsi_div #(.DW(HW), .QB(QB), .TW(2)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v7_ff),
      .n        (num7_ff),
      .d        (a7_ff),
      .in_tag   ({hit7_ff, sat7_ff}),
      .out_valid(dv_valid),
      .q        (dv_q),
      .out_tag  (dv_tag)
   );

   always_comb begin
      if (!dv_tag[1]) begin
         rsp_hit_distance_in = '0;
      end else if (dv_tag[0]) begin
         rsp_hit_distance_in = '1;
      end else begin
         rsp_hit_distance_in = dv_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
      if (en) begin
         rsp_hit_ff          <= dv_tag[1];
         rsp_hit_distance_ff <= rsp_hit_distance_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_distance = rsp_hit_distance_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_hit_distance_ff == '0))
      else $error("A miss carries a nonzero distance.");

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_hit_distance_ff != '0))
      else $error("A hit carries a zero distance.");

   a_frozen: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(dv_valid) && $stable(sq_valid)))
      else $error("Pipeline moved while the result was held.");

endmodule

[hdl/ray_sphere_intersect_unit.sv]
// Ray against sphere intersection unit: register file and front and back ends.
//
// Usage: each transfer on the req_ channel carries one ray (origin and
// direction, signed fixed point with FRAC_BITS fraction bits). Each ray
// gives exactly one transfer on the rsp_ channel, in order: rsp_hit and
// rsp_hit_distance, the nearer positive ray parameter, saturated, zero on
// a miss. The sphere center, radius and active flag are written through
// the csr_ port; the user must write them only while no ray is in flight,
// and nothing in the block enforces this.
// Throughput is one ray per cycle while rsp_stall stays low. The
// bit-per-stage square root and the bit-per-stage divider make up most of
// the pipeline stages.
// Reset empties the pipeline and the queue and returns the registers to
// center zero, radius one half and target inactive.
// While rsp_valid and rsp_stall are both high the back end holds; the front end
// keeps taking rays until its four-entry queue fills, then raises req_stall.
module ray_sphere_intersect_unit
   import rsi_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_origin_z,
   input  logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_dir_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [COORD_WIDTH-2:0]        rsp_hit_distance,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_data
);

   localparam int CW = COORD_WIDTH;
   localparam logic [CW-2:0] RADIUS_RESET = (CW-1)'(1) << (FRAC_BITS - 1);

   logic signed [CW-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [CW-2:0]        sphere_radius_ff;
   logic                 target_active_ff;
   logic                 head_valid, head_pop;
   logic [6*CW+3:0]      head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= '0;
         center_y_ff      <= '0;
         center_z_ff      <= '0;
         sphere_radius_ff <= RADIUS_RESET;
         target_active_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X: center_x_ff      <= csr_data;
            CSR_CENTER_Y: center_y_ff      <= csr_data;
            CSR_CENTER_Z: center_z_ff      <= csr_data;
            CSR_RADIUS:   sphere_radius_ff <= csr_data[CW-2:0];
            CSR_ACTIVE:   target_active_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   rsi_front #(.CW(CW)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_origin_z (req_origin_z),
      .req_dir_x    (req_dir_x),
      .req_dir_y    (req_dir_y),
      .req_dir_z    (req_dir_z),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .center_z     (center_z_ff),
      .target_active(target_active_ff),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .head_pop     (head_pop)
   );

   rsi_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop),
      .sphere_radius   (sphere_radius_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_hit_distance(rsp_hit_distance)
   );

endmodule

[tb/ray_sphere_intersect_unit_tb.sv]
// Self-checking testbench for the ray and sphere intersection unit.
module ray_sphere_intersect_unit_tb;
   import rsi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam logic [CW-2:0] DIST_MAX = '1;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [CW-1:0] ox, oy, oz, dx, dy, dz;
   } ray_type;

   typedef struct {
      logic          hit;
      logic [CW-2:0] distance;
   } hit_type;

   class hit_scoreboard;
      logic signed [CW-1:0] cen_x, cen_y, cen_z;
      logic [CW-2:0]        radius;
      logic                 active;
      hit_type              expected_hits[$];
      int                   errors;

      function new();
         cen_x = 0; cen_y = 0; cen_z = 0;
         radius = 32768; active = 0; errors = 0;
      endfunction

      function wide_type int_sqrt(wide_type x);
         wide_type r, cand;
         r = 0;
         for (int i = 80; i >= 0; i--) begin
            cand = r | (wide_type'(1) <<< i);
            if (cand * cand <= x) r = cand;
         end
         return r;
      endfunction

      function bit root_distance(wide_type n, wide_type a, output logic [CW-2:0] distance);
         wide_type quot;
         distance = 0;
         if (n < 0) return 0;
         quot = (n <<< FB) / a;
         if (quot == 0) return 0;
         if (quot > wide_type'(DIST_MAX)) distance = DIST_MAX;
         else distance = quot[CW-2:0];
         return 1;
      endfunction

      function void note_ray(ray_type ray);
         wide_type ox, oy, oz, dx, dy, dz, a, h, c, r, q, s;
         hit_type res;
         res.hit = 0;
         res.distance = 0;
         if (active) begin
            ox = wide_type'(ray.ox) - wide_type'(cen_x);
            oy = wide_type'(ray.oy) - wide_type'(cen_y);
            oz = wide_type'(ray.oz) - wide_type'(cen_z);
            dx = wide_type'(ray.dx);
            dy = wide_type'(ray.dy);
            dz = wide_type'(ray.dz);
            a = dx * dx + dy * dy + dz * dz;
            if (a != 0) begin
               h = ox * dx + oy * dy + oz * dz;
               r = $signed({225'b0, radius});
               c = ox * ox + oy * oy + oz * oz - r * r;
               q = h * h - a * c;
               if (q >= 0) begin
                  s = int_sqrt(q);
                  if (root_distance(-h - s, a, res.distance)) res.hit = 1;
                  else if (root_distance(-h + s, a, res.distance)) res.hit = 1;
               end
            end
         end
         expected_hits.push_back(res);
      endfunction

      function void check_hit(logic hit, logic [CW-2:0] distance);
         hit_type e;
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result hit=%0d distance=%0h", $time, hit, distance);
            errors++;
            return;
         end
         e = expected_hits.pop_front();
         if (hit !== e.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, hit);
            errors++;
         end
         if (distance !== e.distance) begin
            $display("%0t: distance expected %0h actual %0h", $time, e.distance, distance);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [CW-1:0] req_origin_x, req_origin_y, req_origin_z;
   logic signed [CW-1:0] req_dir_x, req_dir_y, req_dir_z;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_hit;
   logic [CW-2:0]        rsp_hit_distance;
   logic                 csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CW-1:0]        csr_data;

   hit_scoreboard sb = new();
   bit            quiet = 0;

   ray_sphere_intersect_unit i_dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_origin_x, .req_origin_y, .req_origin_z,
      .req_dir_x, .req_dir_y, .req_dir_z,
      .rsp_valid, .rsp_stall, .rsp_hit, .rsp_hit_distance,
      .csr_write, .csr_index, .csr_data
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_hit(rsp_hit, rsp_hit_distance);
   end

   initial begin
      #(12ns * 400000);
      $display("ray_sphere_intersect_unit test failed");
      $finish;
   end

   task automatic write_csr(csr_index_type idx, logic [CW-1:0] value);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         CSR_CENTER_X: sb.cen_x  = value;
         CSR_CENTER_Y: sb.cen_y  = value;
         CSR_CENTER_Z: sb.cen_z  = value;
         CSR_RADIUS:   sb.radius = value[CW-2:0];
         CSR_ACTIVE:   sb.active = value[0];
         default: ;
      endcase
   endtask

   task automatic set_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                             logic [CW-1:0] rad, logic act);
      @(negedge clock);
      req_valid <= 0;
      wait (sb.expected_hits.size() == 0);
      repeat (4) @(posedge clock);
      write_csr(CSR_CENTER_X, cx);
      write_csr(CSR_CENTER_Y, cy);
      write_csr(CSR_CENTER_Z, cz);
      write_csr(CSR_RADIUS, rad);
      write_csr(CSR_ACTIVE, {31'b0, act});
   endtask

   task automatic send_ray(ray_type ray);
      @(negedge clock);
      req_valid    <= 1;
      req_origin_x <= ray.ox; req_origin_y <= ray.oy; req_origin_z <= ray.oz;
      req_dir_x    <= ray.dx; req_dir_y    <= ray.dy; req_dir_z    <= ray.dz;
      do @(posedge clock); while (req_stall);
      sb.note_ray(ray);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat ($urandom_range(0, 13)) @(negedge clock);
      end
   endtask

   function automatic ray_type make_ray(logic signed [CW-1:0] ox, logic signed [CW-1:0] oy,
                                        logic signed [CW-1:0] oz, logic signed [CW-1:0] dx,
                                        logic signed [CW-1:0] dy, logic signed [CW-1:0] dz);
      ray_type ray;
      ray.ox = ox; ray.oy = oy; ray.oz = oz;
      ray.dx = dx; ray.dy = dy; ray.dz = dz;
      return ray;
   endfunction

   function automatic ray_type random_ray();
      ray_type ray;
      logic signed [CW-1:0] off_x, off_y, off_z;
      int span;
      if ($urandom_range(0, 3) == 0) begin
         ray.ox = $urandom; ray.oy = $urandom; ray.oz = $urandom;
         ray.dx = $urandom; ray.dy = $urandom; ray.dz = $urandom;
         return ray;
      end
      span  = $urandom_range(4, 24);
      off_x = $signed($urandom_range(0, (1 << span) - 1)) - (1 <<< (span - 1));
      off_y = $signed($urandom_range(0, (1 << span) - 1)) - (1 <<< (span - 1));
      off_z = $signed($urandom_range(0, (1 << span) - 1)) - (1 <<< (span - 1));
      ray.ox = sb.cen_x + off_x;
      ray.oy = sb.cen_y + off_y;
      ray.oz = sb.cen_z + off_z;
      ray.dx = -off_x + $signed($urandom_range(0, 255)) - 128;
      ray.dy = -off_y + $signed($urandom_range(0, 255)) - 128;
      ray.dz = -off_z + $signed($urandom_range(0, 255)) - 128;
      if ($urandom_range(0, 5) == 0) ray.dx = -ray.dx;
      if ($urandom_range(0, 7) == 0) ray.dy = ray.dy >>> $urandom_range(0, 20);
      return ray;
   endfunction

   initial begin
      reset = 1;
      req_valid = 0;
      req_origin_x = 0; req_origin_y = 0; req_origin_z = 0;
      req_dir_x = 0; req_dir_y = 0; req_dir_z = 0;
      rsp_stall = 0;
      csr_write = 0;
      csr_index = CSR_CENTER_X;
      csr_data = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      fork
         forever begin
            @(negedge clock);
            if (!quiet && $urandom_range(0, 3) == 0) begin
               rsp_stall <= 1;
               repeat ($urandom_range(1, 14)) @(negedge clock);
               rsp_stall <= 0;
            end
            repeat ($urandom_range(0, 20)) @(negedge clock);
         end
      join_none

      // Reset settings: the target is inactive, so every ray misses.
      send_ray(make_ray(-(1 <<< 17), 0, 0, 1 <<< 16, 0, 0));
      send_ray(make_ray('h7fffffff, 'h80000000, 0, 'h80000000, 'h7fffffff, -1));

      set_sphere(0, 0, 0, 1 <<< 16, 1);
      send_ray(make_ray(-(5 <<< 16), 0, 0, 1 <<< 16, 0, 0));
      send_ray(make_ray(-(5 <<< 16), 0, 0, 0, 0, 0));
      send_ray(make_ray(-(5 <<< 16), 3 <<< 16, 0, 1 <<< 16, 0, 0));
      send_ray(make_ray(0, 0, 0, 0, 1 <<< 16, 0));
      send_ray(make_ray(5 <<< 16, 0, 0, 1 <<< 16, 0, 0));
      send_ray(make_ray(-(1 <<< 16), 0, 0, 0, 0, 1 <<< 16));
      send_ray(make_ray(-(5 <<< 16), 1 <<< 16, 0, 1 <<< 16, 0, 0));
      send_ray(make_ray('h80000000, 0, 0, 1, 0, 0));
      send_ray(make_ray('h80000000, 'h80000000, 'h80000000,
                        'h7fffffff, 'h7fffffff, 'h7fffffff));
      send_ray(make_ray('h7fffffff, 'h7fffffff, 'h7fffffff,
                        'h80000000, 'h80000000, 'h80000000));
      send_ray(make_ray(-1, -1, -1, -1, -1, -1));
      send_ray(make_ray(-(5 <<< 16), 0, 0, 'h80000000, 0, 0));

      set_sphere('h7fffffff, 'h80000000, 'h7fffffff, 'h7fffffff, 1);
      send_ray(make_ray('h80000000, 'h7fffffff, 'h80000000, 1, -1, 1));
      send_ray(make_ray(0, 0, 0, 'h7fffffff, 'h80000000, 'h7fffffff));
      send_ray(make_ray('h7fffffff, 'h80000000, 'h7fffffff, 1, 0, 0));

      set_sphere(12 <<< 16, -(3 <<< 16), 7 <<< 16, 0, 1);
      send_ray(make_ray(0, -(3 <<< 16), 7 <<< 16, 1 <<< 16, 0, 0));
      send_ray(make_ray(12 <<< 16, -(3 <<< 16), 7 <<< 16, 1 <<< 16, 0, 0));

      for (int phase = 0; phase < 6; phase++) begin
         logic [CW-1:0] rad;
         if (phase == 5) quiet = 1;
         case (phase)
            0: rad = 1 <<< 16;
            1: rad = $urandom_range(1, 1 << 24);
            2: rad = 'h7fffffff;
            3: rad = $urandom_range(0, 1 << 20);
            default: rad = $urandom_range(1 << 10, 1 << 22);
         endcase
         set_sphere($urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 22)) - (1 <<< 21),
                    $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 22)) - (1 <<< 21),
                    $urandom, rad, phase != 4);
         for (int n = 0; n < 180; n++) begin
            if (phase == 1 && n == 90) begin
               @(negedge clock);
               req_valid <= 0;
               wait (sb.expected_hits.size() == 0);
            end
            send_ray(random_ray());
         end
      end

      @(negedge clock);
      req_valid <= 0;
      wait (sb.expected_hits.size() == 0);
      repeat (130) @(posedge clock);
      if (sb.errors == 0) $display("ray_sphere_intersect_unit test passed");
      else $display("ray_sphere_intersect_unit test failed");
      $finish;
   end
endmodule
